### hw/rtl/lkd_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkd_pkg
// Shared types and constants for the three-wire LED/key driver serial master.
// ----------------------------------------------------------------------------
package lkd_pkg;

    // Request codes carried in the action field
    typedef enum logic [2:0] {
        ACT_TICK   = 3'd0,
        ACT_RAW    = 3'd1,
        ACT_WRITE  = 3'd2,
        ACT_READ   = 3'd3,
        ACT_BRIGHT = 3'd4
    } t_action;

    // Sequencer steps
    typedef enum logic [2:0] {
        STEP_IDLE   = 3'd0,
        STEP_SINGLE = 3'd1,
        STEP_WR_A   = 3'd2,
        STEP_GAP    = 3'd3,
        STEP_WR_B   = 3'd4,
        STEP_RD_CMD = 3'd5,
        STEP_RD_RX  = 3'd6
    } t_step;

    // Command bytes of the driver chip
    localparam logic [7:0] CMD_WRITE_FIXED = 8'h44;
    localparam logic [7:0] CMD_ADDR        = 8'hC0;
    localparam logic [7:0] CMD_READ_KEYS   = 8'h42;
    localparam logic [7:0] CMD_BRIGHT      = 8'h88;
    localparam logic [7:0] BRIGHT_MAX      = 8'd7;
    localparam logic [2:0] BIT_LAST        = 3'd7;

    // Complete sequencer state
    typedef struct packed {
        t_step       step;
        logic [7:0]  half_cnt;
        logic        phase;
        logic [2:0]  bit_idx;
        logic [2:0]  byte_idx;
        logic [7:0]  shift;
        logic [7:0]  held_data;
        logic [3:0]  held_addr;
        logic [7:0]  key_acc;
        logic        strobe;
        logic        dio_bit;
    } t_lkd_state;

    localparam t_lkd_state LKD_STATE_RESET = '{
        step:      STEP_IDLE,
        half_cnt:  8'd0,
        phase:     1'b0,
        bit_idx:   3'd0,
        byte_idx:  3'd0,
        shift:     8'd0,
        held_data: 8'd0,
        held_addr: 4'd0,
        key_acc:   8'd0,
        strobe:    1'b1,
        dio_bit:   1'b0
    };

    // Per-item status produced alongside the next state
    typedef struct packed {
        logic       done;
        logic       rejected;
        logic [7:0] keys;
    } t_lkd_status;

endpackage

### hw/rtl/lkd_step.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkd_step
// Next-state logic of the serial sequencer for one item (request or tick).
// ----------------------------------------------------------------------------
module lkd_step #(
    parameter int KEY_BYTES = 4
) (
    input  lkd_pkg::t_lkd_state  i_state,
    input  logic [2:0]           i_action,
    input  logic [7:0]           i_byte_value,
    input  logic [3:0]           i_address,
    input  logic                 i_dio_in,
    input  logic [7:0]           i_half_period,
    output lkd_pkg::t_lkd_state  o_state,
    output lkd_pkg::t_lkd_status o_status
);
    import lkd_pkg::*;

    localparam logic [3:0] KEY_COUNT = 4'(KEY_BYTES);

    // Load a new byte and set up its first bit, clock low
    function automatic t_lkd_state load_byte(input t_lkd_state s, input logic [7:0] v);
        t_lkd_state r;
        r          = s;
        r.shift    = v;
        r.bit_idx  = 3'd0;
        r.phase    = 1'b0;
        r.half_cnt = 8'd0;
        r.dio_bit  = v[0];
        return r;
    endfunction

    logic       busy;
    logic [7:0] half_len;
    logic [7:0] cnt_inc;
    logic [2:0] bit_inc;
    logic [7:0] bright;
    logic [7:0] acc;
    t_lkd_state n;

    assign busy     = (i_state.step != STEP_IDLE);
    assign half_len = (i_half_period == 8'd0) ? 8'd1 : i_half_period;
    assign cnt_inc  = i_state.half_cnt + 8'd1;
    assign bit_inc  = i_state.bit_idx + 3'd1;
    assign bright   = CMD_BRIGHT | ((i_byte_value > BRIGHT_MAX) ? BRIGHT_MAX : i_byte_value);
    assign acc      = i_state.key_acc | (i_state.shift << i_state.byte_idx);

    always_comb begin
        n        = i_state;
        o_status = '0;
        if (i_action inside {[ACT_RAW:ACT_BRIGHT]}) begin
            if (busy) begin
                o_status.rejected = 1'b1;
            end else begin
                n.strobe   = 1'b0;
                n.byte_idx = 3'd0;
                case (i_action)
                    ACT_RAW: begin
                        n.step = STEP_SINGLE;
                        n      = load_byte(n, i_byte_value);
                    end
                    ACT_WRITE: begin
                        n.held_data = i_byte_value;
                        n.held_addr = i_address;
                        n.step      = STEP_WR_A;
                        n           = load_byte(n, CMD_WRITE_FIXED);
                    end
                    ACT_READ: begin
                        n.step = STEP_RD_CMD;
                        n      = load_byte(n, CMD_READ_KEYS);
                    end
                    default: begin
                        n.step = STEP_SINGLE;
                        n      = load_byte(n, bright);
                    end
                endcase
            end
        end else if (busy) begin
            if (cnt_inc < half_len) begin
                n.half_cnt = cnt_inc;
            end else begin
                n.half_cnt = 8'd0;
                if (i_state.step == STEP_GAP) begin
                    // reopen the frame with the address byte
                    n.strobe   = 1'b0;
                    n.byte_idx = 3'd0;
                    n.step     = STEP_WR_B;
                    n          = load_byte(n, CMD_ADDR | {4'd0, i_state.held_addr});
                end else if (!i_state.phase) begin
                    if (i_state.step == STEP_RD_RX && i_dio_in) begin
                        n.shift[i_state.bit_idx] = 1'b1;
                    end
                    n.phase = 1'b1;
                end else if (i_state.bit_idx < BIT_LAST) begin
                    n.bit_idx = bit_inc;
                    n.phase   = 1'b0;
                    if (i_state.step != STEP_RD_RX) begin
                        n.dio_bit = i_state.shift[bit_inc];
                    end
                end else begin
                    case (i_state.step)
                        STEP_WR_A: begin
                            n.strobe = 1'b1;
                            n.step   = STEP_GAP;
                        end
                        STEP_WR_B: begin
                            if (i_state.byte_idx == 3'd0) begin
                                n.byte_idx = 3'd1;
                                n          = load_byte(n, i_state.held_data);
                            end else begin
                                n.strobe      = 1'b1;
                                n.step        = STEP_IDLE;
                                o_status.done = 1'b1;
                            end
                        end
                        STEP_RD_CMD: begin
                            n.step     = STEP_RD_RX;
                            n.byte_idx = 3'd0;
                            n.key_acc  = 8'd0;
                            n          = load_byte(n, 8'd0);
                        end
                        STEP_RD_RX: begin
                            n.key_acc = acc;
                            if (({1'b0, i_state.byte_idx} + 4'd1) >= KEY_COUNT) begin
                                o_status.keys = acc;
                                o_status.done = 1'b1;
                                n.strobe      = 1'b1;
                                n.step        = STEP_IDLE;
                            end else begin
                                n.byte_idx = i_state.byte_idx + 3'd1;
                                n          = load_byte(n, 8'd0);
                            end
                        end
                        default: begin
                            n.strobe      = 1'b1;
                            n.step        = STEP_IDLE;
                            o_status.done = 1'b1;
                        end
                    endcase
                end
            end
        end
        o_state = n;
    end

endmodule

### hw/rtl/led_key_driver_serial_master_core.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// led_key_driver_serial_master_core
// Bit-level master for a three-wire LED/key driver (strobe, clock, data).
// ----------------------------------------------------------------------------
// Usage:
//   Input stream (s_axis): one item per request or tick. tuser carries the
//   action (tick, raw command, fixed-address write, key read, brightness);
//   tdata carries the byte value, the display address and the sampled data
//   line level. Each item yields exactly one result item on m_axis that shows
//   the pin levels, busy/done/rejected flags and the key value after it.
//   Configuration: i_cfg_we writes the ticks per serial clock half; write it
//   only while the block is idle and its pipeline is empty.
//   Timing: the result passes the input register, then the result register,
//   before it is valid on m_axis; one item per cycle sustained while
//   m_axis_tready stays high, set by the combinational next-state logic
//   of the sequencer.
//   Reset: synchronous, active low; strobe high, clock low, sequencer idle,
//   half period 1, both pipeline stages empty.
//   Stall: when m_axis_tready is low the result is held, the input register
//   keeps its item and s_axis_tready drops once both stages are full.
// ----------------------------------------------------------------------------
module led_key_driver_serial_master_core #(
    parameter int KEY_BYTES = 4
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_cfg_we,
    input  logic [7:0]  i_cfg_wdata,   // half_period
    input  logic        s_axis_tvalid,
    output logic        s_axis_tready,
    input  logic [15:0] s_axis_tdata,  // byte_value[7:0], address[11:8], dio_in[12], zero pad
    input  logic [2:0]  s_axis_tuser,  // action[2:0]
    output logic        m_axis_tvalid,
    input  logic        m_axis_tready,
    // stb_level[0], clk_level[1], dio_out[2], dio_drive[3], busy_res[4],
    // done_res[5], keys[13:6], rejected[14], zero pad[15]
    output logic [15:0] m_axis_tdata
);
    import lkd_pkg::*;

    // Configuration register
    logic [7:0]  r_half_period;

    // Input register
    logic        r_in_valid;
    logic [2:0]  r_in_action;
    logic [7:0]  r_in_byte;
    logic [3:0]  r_in_addr;
    logic        r_in_dio;

    // Sequencer state and result register
    t_lkd_state  r_state;
    t_lkd_state  n_state;
    t_lkd_status n_status;
    logic        r_out_valid;
    logic [15:0] r_out_data;
    logic [15:0] n_out_data;

    logic        out_free;
    logic        advance;
    logic        drive;

    // The result slot frees when empty or taken this cycle
    assign out_free      = !r_out_valid || m_axis_tready;
    assign advance       = r_in_valid && out_free;
    assign s_axis_tready = !r_in_valid || out_free;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_half_period <= 8'd1;
        end else if (i_cfg_we) begin
            r_half_period <= i_cfg_wdata;
        end
    end

    // Capture the item; hold it while the result slot is full
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
        end else if (s_axis_tready) begin
            r_in_valid <= s_axis_tvalid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (s_axis_tvalid && s_axis_tready) begin
            r_in_action <= s_axis_tuser;
            r_in_byte   <= s_axis_tdata[7:0];
            r_in_addr   <= s_axis_tdata[11:8];
            r_in_dio    <= s_axis_tdata[12];
        end
    end

    lkd_step #(
        .KEY_BYTES (KEY_BYTES)
    ) u_step (
        .i_state       (r_state),
        .i_action      (r_in_action),
        .i_byte_value  (r_in_byte),
        .i_address     (r_in_addr),
        .i_dio_in      (r_in_dio),
        .i_half_period (r_half_period),
        .o_state       (n_state),
        .o_status      (n_status)
    );

    // Data line is released only while receiving key bytes
    assign drive = (n_state.step != STEP_RD_RX);

    assign n_out_data = {1'b0,
                         n_status.rejected,
                         n_status.keys,
                         n_status.done,
                         (n_state.step != STEP_IDLE),
                         drive,
                         drive & n_state.dio_bit,
                         n_state.phase,
                         n_state.strobe};

    // Commit the state only when the item moves into the result slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= LKD_STATE_RESET;
        end else if (advance) begin
            r_state <= n_state;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (out_free) begin
            r_out_valid <= r_in_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (advance) begin
            r_out_data <= n_out_data;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = r_out_data;

endmodule

### hw/rtl/lkd_checker.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lkd_checker
// Port-level checks of the serial master, bound to the top level.
// ----------------------------------------------------------------------------
module lkd_checker (
    input logic        i_clk,
    input logic        i_rst_n,
    input logic        m_axis_tvalid,
    input logic [15:0] m_axis_tdata
);

    // Result stage empty right after reset
    a_reset_empty: assert property (@(posedge i_clk)
        !i_rst_n |=> !m_axis_tvalid)
        else $error("result valid right after reset");

    // A rejected request leaves the running sequence busy
    a_reject_busy: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && m_axis_tdata[14]) |-> m_axis_tdata[4])
        else $error("rejected item while idle");

    // Idle means strobe high
    a_idle_strobe: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[4]) |-> m_axis_tdata[0])
        else $error("strobe low while idle");

    // Keys only on a finishing item, and a finish ends busy
    a_keys_done: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && (m_axis_tdata[13:6] != 8'd0)) |-> (m_axis_tdata[5] && !m_axis_tdata[4]))
        else $error("key value outside a finishing item");

    // Released data line reads as zero
    a_release_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (m_axis_tvalid && !m_axis_tdata[3]) |-> !m_axis_tdata[2])
        else $error("data driven high while released");

endmodule

bind led_key_driver_serial_master_core lkd_checker u_lkd_checker (.*);
